// ===== sv/iol_pkg.sv =====
// Shared types and codes for the indexed ordered list unit.
package iol_pkg;

  typedef enum logic [2:0] {
    REQ_INS_AT    = 3'd0,
    REQ_INS_FRONT = 3'd1,
    REQ_INS_BACK  = 3'd2,
    REQ_REM_AT    = 3'd3,
    REQ_REM_FRONT = 3'd4,
    REQ_REM_BACK  = 3'd5,
    REQ_READ      = 3'd6,
    REQ_CLEAR     = 3'd7
  } req_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    SHIFT_HOLD   = 2'd0,
    SHIFT_INSERT = 2'd1,
    SHIFT_REMOVE = 2'd2
  } shift_op_t;

  localparam int unsigned POS_W   = 4;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned COUNT_W = 5;

  typedef struct packed {
    status_t status;
    logic    take;
  } ctl_resp_t;

  typedef struct packed {
    logic [WORD_W-1:0]  read_value;
    status_t            status;
    logic [COUNT_W-1:0] entry_count;
  } out_item_t;

endpackage

// ===== sv/indexed_ordered_list_unit.sv =====
// Top level of the indexed ordered list unit: decoder, cell chain and output buffer.
//
// Usage:
//   Each request transaction on the in_ channel carries a request kind in
//   in_tuser and a position and data word in in_tdata. Kinds: insert at
//   position, insert front, insert back, remove at position, remove front,
//   remove back, read at position, clear. Every request gives exactly one
//   result transaction on the out_ channel with the removed or read word,
//   a status code and the entry count after the request.
//   Entries live in a row of CAPACITY cells; an insert or remove shifts every
//   cell past the position by one place in the same cycle, so a new request
//   can be taken every cycle while in_tready is high.
//   Each result is registered, in the output slot or the skid stage, before out_tvalid shows it.
//   Throughput: one request per cycle while the receiver keeps up.
//   When the receiver stalls, one further result is held in a skid stage;
//   in_tready then drops until the output register drains.
//   Reset (rst_n low, synchronous) empties the list and both output slots;
//   cell contents are not cleared, entries beyond the count are never read.
module indexed_ordered_list_unit #(
  parameter int unsigned CAPACITY   = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [3:0] position, [35:4] item_value, [39:36] zero
  input  logic [2:0]  in_tuser,   // [2:0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] read_value, [36:32] entry_count, [39:37] zero
  output logic [1:0]  out_tuser   // [1:0] status
);

  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  logic                  accept;
  iol_pkg::req_t         req;
  logic [3:0]            position;
  logic [31:0]           item_value;
  logic [63:0]           item_wide;
  logic [DATA_WIDTH-1:0] ins_word;
  iol_pkg::shift_op_t    op;
  logic [IDX_W-1:0]      at_idx;
  iol_pkg::ctl_resp_t    resp;
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      count_after;
  logic [31:0]           count_wide;
  logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
  logic [DATA_WIDTH-1:0] rd_bus [CAPACITY];
  logic [DATA_WIDTH-1:0] rd_or;
  logic [63:0]           rd_wide;
  iol_pkg::out_item_t    result;
  iol_pkg::out_item_t    out_item;
  logic                  can_push;

  assign req        = iol_pkg::req_t'(in_tuser[2:0]);
  assign position   = in_tdata[3:0];
  assign item_value = in_tdata[35:4];
  assign item_wide  = 64'(item_value);
  assign ins_word   = item_wide[DATA_WIDTH-1:0];
  assign in_tready  = can_push;
  assign accept     = in_tvalid && can_push;

  iol_ctrl #(
    .CAPACITY (CAPACITY),
    .IDX_W    (IDX_W),
    .CNT_W    (CNT_W)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .req         (req),
    .position    (position),
    .op          (op),
    .at_idx      (at_idx),
    .resp        (resp),
    .count       (count),
    .count_after (count_after)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_data;
    logic [DATA_WIDTH-1:0] right_data;
    if (i == 0) begin : g_first
      assign left_data = '0;
    end else begin : g_mid_l
      assign left_data = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_data = cell_data[i];
    end else begin : g_mid_r
      assign right_data = cell_data[i+1];
    end
    iol_cell #(
      .IDX_W      (IDX_W),
      .DATA_WIDTH (DATA_WIDTH),
      .IDX        (i)
    ) u_cell (
      .clk        (clk),
      .op         (op),
      .at_idx     (at_idx),
      .ins_word   (ins_word),
      .left_data  (left_data),
      .right_data (right_data),
      .data       (cell_data[i]),
      .rd_data    (rd_bus[i])
    );
  end

  always_comb begin
    rd_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_or = rd_or | rd_bus[i];
    end
  end

  assign rd_wide           = 64'(rd_or);
  assign count_wide        = 32'(count_after);
  assign result.read_value = resp.take ? rd_wide[31:0] : '0;
  assign result.status     = resp.status;
  assign result.entry_count = count_wide[4:0];

  iol_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_item (result),
    .can_push  (can_push),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_item  (out_item)
  );

  assign out_tdata = {3'b000, out_item.entry_count, out_item.read_value};
  assign out_tuser = out_item.status;

`ifndef SYNTH
  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count <= CNT_W'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_stall_holds_output : assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("skid stage full without a pending output");

  a_read_keeps_count : assert property (@(posedge clk) disable iff (!rst_n)
    accept && req == iol_pkg::REQ_READ |=> $stable(count))
    else $error("read changed the entry count");

  a_refused_keeps_count : assert property (@(posedge clk) disable iff (!rst_n)
    accept && resp.status != iol_pkg::ST_OK |=> $stable(count))
    else $error("refused request changed the entry count");

  a_clear_empties : assert property (@(posedge clk) disable iff (!rst_n)
    accept && req == iol_pkg::REQ_CLEAR |=> count == '0)
    else $error("clear left entries behind");
`endif

endmodule

// ===== sv/iol_cell.sv =====
// One list cell: holds one entry and shifts with its neighbors.
module iol_cell #(
  parameter int unsigned IDX_W      = 4,
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned IDX        = 0
) (
  input  logic                  clk,
  input  iol_pkg::shift_op_t    op,
  input  logic [IDX_W-1:0]      at_idx,
  input  logic [DATA_WIDTH-1:0] ins_word,
  input  logic [DATA_WIDTH-1:0] left_data,
  input  logic [DATA_WIDTH-1:0] right_data,
  output logic [DATA_WIDTH-1:0] data,
  output logic [DATA_WIDTH-1:0] rd_data
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    case (op)
      iol_pkg::SHIFT_INSERT: begin
        if (MY_IDX == at_idx) begin
          data_nxt = ins_word;
        end else if (MY_IDX > at_idx) begin
          data_nxt = left_data;
        end
      end
      iol_pkg::SHIFT_REMOVE: begin
        if (MY_IDX >= at_idx) begin
          data_nxt = right_data;
        end
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data    = data_r;
  assign rd_data = (MY_IDX == at_idx) ? data_r : '0;

endmodule

// ===== sv/iol_ctrl.sv =====
// Request decoder and entry counter that steer the cell chain.
module iol_ctrl #(
  parameter int unsigned CAPACITY = 16,
  parameter int unsigned IDX_W    = 4,
  parameter int unsigned CNT_W    = 5
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           accept,
  input  iol_pkg::req_t                  req,
  input  logic [iol_pkg::POS_W-1:0]      position,
  output iol_pkg::shift_op_t             op,
  output logic [IDX_W-1:0]               at_idx,
  output iol_pkg::ctl_resp_t             resp,
  output logic [CNT_W-1:0]               count,
  output logic [CNT_W-1:0]               count_after
);

  localparam int unsigned CMP_W = (CNT_W > iol_pkg::POS_W) ? CNT_W : iol_pkg::POS_W;
  localparam logic [CNT_W-1:0] CAP = CNT_W'(CAPACITY);

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] cnt_ext;
  logic             pos_ok;
  logic             full;
  logic             empty;
  iol_pkg::shift_op_t dec_op;

  assign pos_ext = CMP_W'(position);
  assign cnt_ext = CMP_W'(count_r);
  assign pos_ok  = pos_ext < cnt_ext;
  assign full    = count_r == CAP;
  assign empty   = count_r == '0;

  always_comb begin
    dec_op      = iol_pkg::SHIFT_HOLD;
    at_idx      = IDX_W'(position);
    resp.status = iol_pkg::ST_OK;
    resp.take   = 1'b0;
    count_after = count_r;
    unique case (req) inside
      iol_pkg::REQ_INS_AT: begin
        if (!pos_ok) begin
          resp.status = iol_pkg::ST_RANGE;
        end else if (full) begin
          resp.status = iol_pkg::ST_FULL;
        end else begin
          dec_op      = iol_pkg::SHIFT_INSERT;
          count_after = count_r + CNT_W'(1);
        end
      end
      iol_pkg::REQ_INS_FRONT, iol_pkg::REQ_INS_BACK: begin
        at_idx = (req == iol_pkg::REQ_INS_FRONT) ? '0 : IDX_W'(count_r);
        if (full) begin
          resp.status = iol_pkg::ST_FULL;
        end else begin
          dec_op      = iol_pkg::SHIFT_INSERT;
          count_after = count_r + CNT_W'(1);
        end
      end
      iol_pkg::REQ_REM_AT, iol_pkg::REQ_REM_FRONT, iol_pkg::REQ_REM_BACK: begin
        if (req == iol_pkg::REQ_REM_FRONT) begin
          at_idx = '0;
        end else if (req == iol_pkg::REQ_REM_BACK) begin
          at_idx = IDX_W'(count_r - CNT_W'(1));
        end
        if (empty) begin
          resp.status = iol_pkg::ST_EMPTY;
        end else if (req == iol_pkg::REQ_REM_AT && !pos_ok) begin
          resp.status = iol_pkg::ST_RANGE;
        end else begin
          dec_op      = iol_pkg::SHIFT_REMOVE;
          resp.take   = 1'b1;
          count_after = count_r - CNT_W'(1);
        end
      end
      iol_pkg::REQ_READ: begin
        if (!pos_ok) begin
          resp.status = iol_pkg::ST_RANGE;
        end else begin
          resp.take = 1'b1;
        end
      end
      iol_pkg::REQ_CLEAR: begin
        count_after = '0;
      end
      default: begin
        count_after = count_r;
      end
    endcase
  end

  assign op        = accept ? dec_op : iol_pkg::SHIFT_HOLD;
  assign count_nxt = accept ? count_after : count_r;
  assign count     = count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

endmodule

// ===== sv/iol_skid.sv =====
// Output register with a skid stage for result transactions.
module iol_skid (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  iol_pkg::out_item_t push_item,
  output logic               can_push,
  output logic               out_valid,
  input  logic               out_ready,
  output iol_pkg::out_item_t out_item
);

  logic               out_v_r;
  logic               out_v_nxt;
  logic               skid_v_r;
  logic               skid_v_nxt;
  iol_pkg::out_item_t out_r;
  iol_pkg::out_item_t out_nxt;
  iol_pkg::out_item_t skid_r;
  iol_pkg::out_item_t skid_nxt;

  always_comb begin
    out_v_nxt  = out_v_r;
    skid_v_nxt = skid_v_r;
    out_nxt    = out_r;
    skid_nxt   = skid_r;
    if (!out_v_r || out_ready) begin
      if (skid_v_r) begin
        out_nxt    = skid_r;
        out_v_nxt  = 1'b1;
        skid_v_nxt = 1'b0;
      end else if (push) begin
        out_nxt   = push_item;
        out_v_nxt = 1'b1;
      end else begin
        out_v_nxt = 1'b0;
      end
    end else if (push) begin
      skid_nxt   = push_item;
      skid_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign can_push  = !skid_v_r;
  assign out_valid = out_v_r;
  assign out_item  = out_r;

endmodule
